// File: rtl/rrpd_pkg.sv
`default_nettype none

package rrpd_pkg;

    localparam int DATA_W  = 32;
    localparam int DIFF_W  = DATA_W + 1;
    localparam int RPROD_W = 2 * DATA_W;
    localparam int TPROD_W = DATA_W + DIFF_W;
    localparam int SUM_W   = TPROD_W + 2;

    typedef logic signed [DATA_W-1:0]  word_t;
    typedef logic signed [DIFF_W-1:0]  diff_t;
    typedef logic signed [RPROD_W-1:0] rprod_t;
    typedef logic signed [TPROD_W-1:0] tprod_t;
    typedef logic signed [SUM_W-1:0]   sum_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] pose_r00;
        logic signed [DATA_W-1:0] pose_r01;
        logic signed [DATA_W-1:0] pose_r02;
        logic signed [DATA_W-1:0] pose_tx;
        logic signed [DATA_W-1:0] pose_r10;
        logic signed [DATA_W-1:0] pose_r11;
        logic signed [DATA_W-1:0] pose_r12;
        logic signed [DATA_W-1:0] pose_ty;
        logic signed [DATA_W-1:0] pose_r20;
        logic signed [DATA_W-1:0] pose_r21;
        logic signed [DATA_W-1:0] pose_r22;
        logic signed [DATA_W-1:0] pose_tz;
    } pose_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] rel_r00;
        logic signed [DATA_W-1:0] rel_r01;
        logic signed [DATA_W-1:0] rel_r02;
        logic signed [DATA_W-1:0] rel_tx;
        logic signed [DATA_W-1:0] rel_r10;
        logic signed [DATA_W-1:0] rel_r11;
        logic signed [DATA_W-1:0] rel_r12;
        logic signed [DATA_W-1:0] rel_ty;
        logic signed [DATA_W-1:0] rel_r20;
        logic signed [DATA_W-1:0] rel_r21;
        logic signed [DATA_W-1:0] rel_r22;
        logic signed [DATA_W-1:0] rel_tz;
    } rel_t;

endpackage

`default_nettype wire

// File: rtl/relative_rigid_pose_delta_top.sv
// Relative rigid pose delta: for each absolute pose [R | t] on the s_ channel
// the block returns inv(current) * previous on the m_ channel, one word out for
// each word in, in order. Rotation: Rcur^T * Rprev; translation:
// Rcur^T * (tprev - tcur). Entries are signed fixed point with FRAC_BITS
// fraction bits, rounded half up and saturated to 32 bits.
// Both channels are valid/ready; a word moves when valid and ready are high.
// m_valid rises once an accepted word has passed the input register, the product
// register (36 parallel multipliers) and sum/round/saturate into the output
// register. Throughput is one pose per cycle while m_ready is high.
// The pipeline advances as a whole; when the output word is held by a low
// m_ready, all stages hold and s_ready drops in the same cycle.
// Synchronous active-low reset empties the pipeline and sets the stored
// previous pose to identity rotation and zero translation, so the first result
// after reset is the rigid inverse of the first pose.
`default_nettype none

module relative_rigid_pose_delta_top #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire rrpd_pkg::pose_t s_pose,
    output logic                m_valid,
    input  wire logic           m_ready,
    output rrpd_pkg::rel_t      m_rel
);

    localparam int SW = rrpd_pkg::SUM_W;
    localparam int DW = rrpd_pkg::DATA_W;

    localparam rrpd_pkg::word_t ONE = DW'(64'd1 << FRAC_BITS);
    localparam rrpd_pkg::sum_t  RND = SW'(1) << (FRAC_BITS - 1);
    localparam rrpd_pkg::sum_t  SAT_MAX = {{(SW-DW+1){1'b0}}, {(DW-1){1'b1}}};
    localparam rrpd_pkg::sum_t  SAT_MIN = {{(SW-DW+1){1'b1}}, {(DW-1){1'b0}}};

    logic adv;
    logic acc;

    rrpd_pkg::word_t cur_rot [9];
    rrpd_pkg::word_t cur_t   [3];

    rrpd_pkg::word_t prev_rot_reg [9];
    rrpd_pkg::word_t prev_t_reg   [3];

    logic            v1_reg;
    logic            v2_reg;
    logic            m_valid_reg;
    rrpd_pkg::word_t rc_reg [9];
    rrpd_pkg::word_t pr_reg [9];
    rrpd_pkg::diff_t d_reg  [3];
    rrpd_pkg::rprod_t rp_reg [27];
    rrpd_pkg::tprod_t tp_reg [9];
    rrpd_pkg::word_t out_reg [12];

    assign adv     = !m_valid_reg || m_ready;
    assign acc     = s_valid && adv;
    assign s_ready = adv;
    assign m_valid = m_valid_reg;

    assign cur_rot[0] = s_pose.pose_r00;
    assign cur_rot[1] = s_pose.pose_r01;
    assign cur_rot[2] = s_pose.pose_r02;
    assign cur_rot[3] = s_pose.pose_r10;
    assign cur_rot[4] = s_pose.pose_r11;
    assign cur_rot[5] = s_pose.pose_r12;
    assign cur_rot[6] = s_pose.pose_r20;
    assign cur_rot[7] = s_pose.pose_r21;
    assign cur_rot[8] = s_pose.pose_r22;
    assign cur_t[0]   = s_pose.pose_tx;
    assign cur_t[1]   = s_pose.pose_ty;
    assign cur_t[2]   = s_pose.pose_tz;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            v1_reg      <= s_valid;
            v2_reg      <= v1_reg;
            m_valid_reg <= v2_reg;
        end
    end

    // stored previous pose and input stage
    for (genvar k = 0; k < 9; k++) begin : g_rot
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                prev_rot_reg[k] <= (k % 4 == 0) ? ONE : '0;
            end else if (acc) begin
                prev_rot_reg[k] <= cur_rot[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                rc_reg[k] <= cur_rot[k];
                pr_reg[k] <= prev_rot_reg[k];
            end
        end
    end

    for (genvar k = 0; k < 3; k++) begin : g_trn
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                prev_t_reg[k] <= '0;
            end else if (acc) begin
                prev_t_reg[k] <= cur_t[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                d_reg[k] <= rrpd_pkg::DIFF_W'(prev_t_reg[k]) - rrpd_pkg::DIFF_W'(cur_t[k]);
            end
        end
    end

    // product stage: row i of Rcur^T is column i of Rcur
    for (genvar i = 0; i < 3; i++) begin : g_pi
        for (genvar k = 0; k < 3; k++) begin : g_pk
            for (genvar j = 0; j < 3; j++) begin : g_pj
                rrpd_pkg::rprod_t rp_next;
                assign rp_next = rrpd_pkg::RPROD_W'(rc_reg[k*3+i])
                               * rrpd_pkg::RPROD_W'(pr_reg[k*3+j]);
                always_ff @(posedge aclk) begin
                    if (adv) begin
                        rp_reg[(i*3+j)*3+k] <= rp_next;
                    end
                end
            end

            rrpd_pkg::tprod_t tp_next;
            assign tp_next = rrpd_pkg::TPROD_W'(rc_reg[k*3+i])
                           * rrpd_pkg::TPROD_W'(d_reg[k]);
            always_ff @(posedge aclk) begin
                if (adv) begin
                    tp_reg[i*3+k] <= tp_next;
                end
            end
        end
    end

    // sum, round half up, saturate
    for (genvar i = 0; i < 3; i++) begin : g_oi
        for (genvar j = 0; j < 4; j++) begin : g_oj
            rrpd_pkg::sum_t  sum;
            rrpd_pkg::sum_t  shf;
            rrpd_pkg::word_t out_next;

            if (j < 3) begin : g_r
                assign sum = SW'(rp_reg[(i*3+j)*3+0]) + SW'(rp_reg[(i*3+j)*3+1])
                           + SW'(rp_reg[(i*3+j)*3+2]);
            end else begin : g_t
                assign sum = SW'(tp_reg[i*3+0]) + SW'(tp_reg[i*3+1])
                           + SW'(tp_reg[i*3+2]);
            end

            assign shf = (sum + RND) >>> FRAC_BITS;

            always_comb begin
                if (shf > SAT_MAX) begin
                    out_next = SAT_MAX[DW-1:0];
                end else if (shf < SAT_MIN) begin
                    out_next = SAT_MIN[DW-1:0];
                end else begin
                    out_next = shf[DW-1:0];
                end
            end

            always_ff @(posedge aclk) begin
                if (adv) begin
                    out_reg[i*4+j] <= out_next;
                end
            end
        end
    end

    assign m_rel.rel_r00 = out_reg[0];
    assign m_rel.rel_r01 = out_reg[1];
    assign m_rel.rel_r02 = out_reg[2];
    assign m_rel.rel_tx  = out_reg[3];
    assign m_rel.rel_r10 = out_reg[4];
    assign m_rel.rel_r11 = out_reg[5];
    assign m_rel.rel_r12 = out_reg[6];
    assign m_rel.rel_ty  = out_reg[7];
    assign m_rel.rel_r20 = out_reg[8];
    assign m_rel.rel_r21 = out_reg[9];
    assign m_rel.rel_r22 = out_reg[10];
    assign m_rel.rel_tz  = out_reg[11];

endmodule

`default_nettype wire

// File: rtl/rrpd_checker.sv
`default_nettype none

module rrpd_checker (
    input wire logic            aclk,
    input wire logic            aresetn,
    input wire logic            s_valid,
    input wire logic            s_ready,
    input wire rrpd_pkg::pose_t s_pose,
    input wire logic            m_valid,
    input wire logic            m_ready,
    input wire rrpd_pkg::rel_t  m_rel
);

    logic unused_pose;
    assign unused_pose = ^s_pose;

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("m_valid high after reset");

    a_ready_space: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("s_ready does not follow output space");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_rel))
        else $error("stalled output word changed");

    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) ##1 m_ready ##1 m_ready |=> m_valid)
        else $error("accepted word not delivered after three cycles");

endmodule

bind relative_rigid_pose_delta_top rrpd_checker u_rrpd_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_pose  (s_pose),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_rel   (m_rel)
);

`default_nettype wire

// File: verif/tb_relative_rigid_pose_delta_top.sv
`timescale 1ns / 1ps

module tb_relative_rigid_pose_delta_top;

    typedef rrpd_pkg::word_t word_t;
    typedef rrpd_pkg::pose_t pose_t;
    typedef rrpd_pkg::rel_t  rel_t;

    localparam int FRAC_BITS = 16;
    localparam int W         = rrpd_pkg::DATA_W;
    localparam int NF        = 12;
    localparam int PW        = $bits(pose_t);
    localparam int ACC_W     = 72;
    localparam int RANDOM_N  = 800;

    typedef logic signed [ACC_W-1:0] acc_t;

    typedef struct {
        pose_t pose;
        bit    typed;
        rel_t  want;
    } pose_row_t;

    localparam word_t ONE  = word_t'(1 << FRAC_BITS);
    localparam word_t MAXW = 32'sh7fff_ffff;
    localparam word_t MINW = 32'sh8000_0000;
    localparam acc_t  ACC_MAX = acc_t'(MAXW);
    localparam acc_t  ACC_MIN = acc_t'(MINW);

    logic  aclk    = 1'b0;
    logic  aresetn = 1'b0;
    logic  s_valid = 1'b0;
    logic  s_ready;
    pose_t s_pose  = '0;
    logic  m_valid;
    logic  m_ready = 1'b0;
    rel_t  m_rel;

    logic  s_taken = 1'b0;
    int    sent = 0;
    int    checked = 0;
    int    mismatches = 0;

    word_t     prev_rot [9];
    word_t     prev_tr [3];
    rel_t      expected_rel [$];
    pose_row_t pose_rows [$];

    relative_rigid_pose_delta_top #(
        .FRAC_BITS(FRAC_BITS)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_pose  (s_pose),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_rel   (m_rel)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("relative_rigid_pose_delta_top: mismatch");
        $finish;
    end

    function automatic word_t round_sat(input acc_t sum);
        acc_t v;
        v = (sum + (acc_t'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        if (v > ACC_MAX)
            v = ACC_MAX;
        if (v < ACC_MIN)
            v = ACC_MIN;
        return v[W-1:0];
    endfunction

    function automatic rel_t relative_pose(input pose_t p);
        word_t cur [NF];
        word_t res [NF];
        word_t rc [9];
        word_t tc [3];
        acc_t  d [3];
        acc_t  s;
        rel_t  r;
        int    i, j, k;
        for (k = 0; k < NF; k++)
            cur[k] = p[PW-1-W*k -: W];
        for (i = 0; i < 3; i++) begin
            for (j = 0; j < 3; j++)
                rc[i*3+j] = cur[i*4+j];
            tc[i] = cur[i*4+3];
        end
        for (i = 0; i < 3; i++)
            d[i] = acc_t'(prev_tr[i]) - acc_t'(tc[i]);
        for (i = 0; i < 3; i++) begin
            for (j = 0; j < 3; j++) begin
                s = '0;
                for (k = 0; k < 3; k++)
                    s += acc_t'(rc[k*3+i]) * acc_t'(prev_rot[k*3+j]);
                res[i*4+j] = round_sat(s);
            end
            s = '0;
            for (k = 0; k < 3; k++)
                s += acc_t'(rc[k*3+i]) * d[k];
            res[i*4+3] = round_sat(s);
        end
        for (k = 0; k < 9; k++)
            prev_rot[k] = rc[k];
        for (k = 0; k < 3; k++)
            prev_tr[k] = tc[k];
        for (k = 0; k < NF; k++)
            r[PW-1-W*k -: W] = res[k];
        return r;
    endfunction

    function automatic pose_t diag_pose(input word_t dg, input word_t off, input word_t tr);
        pose_t p;
        int    k;
        for (k = 0; k < NF; k++)
            p[PW-1-W*k -: W] = (k % 4 == 3) ? tr : ((k % 5 == 0) ? dg : off);
        return p;
    endfunction

    function automatic pose_t random_pose();
        pose_t p;
        word_t v;
        int    mode, k;
        mode = $urandom_range(0, 99);
        for (k = 0; k < NF; k++) begin
            if (mode < 60) begin
                if (k % 4 == 3)
                    v = word_t'($urandom) >>> 7;
                else
                    v = word_t'($urandom_range(0, 2 * 65536)) - ONE;
            end else if (mode < 85) begin
                v = word_t'($urandom);
            end else begin
                case ($urandom_range(0, 6))
                    0: v = '0;
                    1: v = ONE;
                    2: v = -ONE;
                    3: v = MAXW;
                    4: v = MINW;
                    5: v = 32'sh0000_0001;
                    default: v = 32'shffff_ffff;
                endcase
            end
            p[PW-1-W*k -: W] = v;
        end
        return p;
    endfunction

    function automatic bit idle_roll();
        if (sent >= 300 && sent < 450)
            return 1'b0;
        return $urandom_range(0, 99) < 21;
    endfunction

    function automatic void add_row(input pose_t p, input bit typed, input rel_t want);
        pose_row_t row;
        row.pose  = p;
        row.typed = typed;
        row.want  = want;
        pose_rows.insert(pose_rows.size(), row);
    endfunction

    task automatic send_pose(input pose_t p, input bit typed, input rel_t want);
        rel_t e;
        if (idle_roll()) begin
            s_valid <= 1'b0;
            do @(negedge aclk); while (idle_roll());
        end
        s_valid <= 1'b1;
        s_pose  <= p;
        do @(negedge aclk); while (!s_taken);
        e = relative_pose(p);
        expected_rel.insert(expected_rel.size(), typed ? want : e);
        sent++;
    endtask

    always @(posedge aclk)
        s_taken <= aresetn && s_valid && s_ready;

    always @(negedge aclk) begin
        if (aresetn)
            m_ready <= !idle_roll();
    end

    always @(posedge aclk) begin : check_rel
        rel_t  want;
        word_t a, b;
        int    k;
        if (aresetn && m_valid && m_ready) begin
            if (expected_rel.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: %h", m_rel);
            end else begin
                want = expected_rel.pop_front();
                for (k = 0; k < NF; k++) begin
                    a = want[PW-1-W*k -: W];
                    b = m_rel[PW-1-W*k -: W];
                    if (a !== b) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result %0d field %0d: expected %h, got %h",
                                     checked, k, a, b);
                    end
                end
            end
            checked++;
        end
    end

    initial begin : stimulus
        pose_t p;
        int    k;
        for (k = 0; k < 9; k++)
            prev_rot[k] = (k % 4 == 0) ? ONE : '0;
        for (k = 0; k < 3; k++)
            prev_tr[k] = '0;

        add_row(diag_pose(ONE, '0, '0), 1'b1, rel_t'(diag_pose(ONE, '0, '0)));
        add_row(diag_pose(ONE, '0, ONE), 1'b1, rel_t'(diag_pose(ONE, '0, -ONE)));
        add_row(diag_pose(MAXW, MAXW, MINW), 1'b1, rel_t'(diag_pose(MAXW, MAXW, MAXW)));
        add_row(diag_pose(MINW, MINW, MAXW), 1'b1, rel_t'(diag_pose(MINW, MINW, MAXW)));
        add_row(diag_pose('0, '0, '0), 1'b1, rel_t'(diag_pose('0, '0, '0)));
        add_row(diag_pose(ONE, '0, '0), 1'b0, '0);
        add_row(diag_pose(32'sh0000_8000, '0, 32'sh0000_0001), 1'b0, '0);
        add_row(diag_pose(32'shffff_8000, 32'sh0000_8001, 32'shffff_ffff), 1'b0, '0);
        p = diag_pose('0, '0, 32'sh0003_0000);
        p.pose_r01 = -ONE;
        p.pose_r10 = ONE;
        p.pose_r22 = ONE;
        add_row(p, 1'b0, '0);
        add_row(diag_pose('0, ONE, 32'shfffe_0000), 1'b0, '0);
        add_row(diag_pose(32'sh5555_5555, 32'shaaaa_aaaa, 32'sh5555_5555), 1'b0, '0);
        add_row(diag_pose(32'shaaaa_aaaa, 32'sh5555_5555, 32'shaaaa_aaaa), 1'b0, '0);
        add_row(diag_pose(-ONE, '0, MAXW), 1'b0, '0);
        add_row(diag_pose(ONE, -ONE, MINW), 1'b0, '0);
        add_row(diag_pose(32'sh0000_0001, 32'shffff_ffff, 32'sh0000_7fff), 1'b0, '0);
        add_row(diag_pose(MAXW, MINW, '0), 1'b0, '0);
        add_row(diag_pose(ONE, '0, '0), 1'b0, '0);

        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (pose_rows[i])
            send_pose(pose_rows[i].pose, pose_rows[i].typed, pose_rows[i].want);
        repeat (RANDOM_N)
            send_pose(random_pose(), 1'b0, '0);
        s_valid <= 1'b0;

        while (expected_rel.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);

        if (mismatches == 0 && expected_rel.size() == 0)
            $display("relative_rigid_pose_delta_top: match");
        else
            $display("relative_rigid_pose_delta_top: mismatch");
        $finish;
    end

endmodule
